### sv/pas_pkg.sv
// shared types and constants for the polyline adaptive subdivider
// no dependencies; used by the channel interfaces and the core
package pas_pkg;

  localparam int COORD_W      = 20;
  localparam int TYPE_W       = 8;
  localparam int CFG_W        = 16;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int MAX_PIECES_DEF = 32;

  localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd256;

  localparam int TYPE_MARKER_BIT = 5;
  localparam int TYPE_END_BIT    = 7;

  // register index, taken from the word address bit
  localparam logic REG_INTERVAL = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [TYPE_W-1:0]         point_type;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_start_x;
    logic signed [COORD_W-1:0] seg_start_y;
    logic signed [COORD_W-1:0] seg_end_x;
    logic signed [COORD_W-1:0] seg_end_y;
    logic                      opens_figure;
    logic                      sets_marker;
    logic                      closes_figure;
    logic                      last_of_run;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SQRT,
    ST_QUOT,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } state_e;

endpackage

### sv/pas_if.sv
// valid/ready channel interfaces for points in and segments out
// depends on pas_pkg
interface pas_point_if;
  import pas_pkg::*;
  logic   valid;
  logic   ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pas_seg_if;
  import pas_pkg::*;
  logic valid;
  logic ready;
  seg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/polyline_adaptive_subdivider_core.sv
// polyline subdivider core: sequencer around one multiplier, sqrt, divider and stepper
// depends on pas_pkg and the channel interfaces in pas_if.sv
// A point is taken only while the core is idle. An edge runs through the multiply, square
// root, count, divide and emit steps in that order, and the emit step holds while the
// segment output is stalled; a figure end adds the same again for the closing edge. The
// time per point is set mostly by the shared serial square root and divider.
module polyline_adaptive_subdivider_core #(
  parameter int MAX_PIECES = pas_pkg::MAX_PIECES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pas_point_if.sink                   point_i,
  pas_seg_if.source                   seg_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pas_pkg::PADDR_W-1:0] paddr,
  input  logic [pas_pkg::PDATA_W-1:0] pwdata,
  output logic [pas_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pas_pkg::*;

  localparam int CNT_W = $clog2(MAX_PIECES + 1);
  localparam int DEN_W = CNT_W + 1;
  localparam int D_W   = COORD_W + 1;
  localparam int SQ_W  = 2 * D_W;
  localparam int RT_W  = D_W + 1;
  localparam int DV_W  = D_W + 1;
  localparam int Q_W   = DV_W + 1;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = DV_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIECES);

  state_e state_q, state_d;

  logic [CFG_W-1:0] interval_q;

  logic signed [COORD_W-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q, fig_x_q, fig_y_q;
  logic signed [COORD_W-1:0] prev_x_d, prev_y_d, cur_x_d, cur_y_d, fig_x_d, fig_y_d;
  logic [TYPE_W-1:0] prev_type_q, prev_type_d, cur_type_q, cur_type_d;
  logic have_prev_q, have_prev_d, skip_q, skip_d, opens_q, opens_d;
  logic edge_close_q, edge_close_d;

  logic [SQ_W-1:0] s_q, s_d, r_q, r_d;
  logic [4:0] it_q, it_d;
  logic [RT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, n_q, n_d, m_q, m_d, k_q, k_d;

  logic [DV_W-1:0] dv_q, dv_d;
  logic [DEN_W-1:0] drem_q, drem_d;
  logic dneg_q, dneg_d;
  logic signed [Q_W-1:0] qx_q, qx_d, qy_q, qy_d, accx_q, accx_d, accy_q, accy_d;
  logic [DEN_W-1:0] rx_q, rx_d, ry_q, ry_d, remx_q, remx_d, remy_q, remy_d;
  logic signed [COORD_W-1:0] px_q, px_d, py_q, py_d;

  logic seg_valid_q, seg_valid_d;
  seg_t seg_q, seg_d;

  // edge endpoints
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic signed [D_W-1:0] dx, dy, dsel;
  logic signed [SQ_W-1:0] prod;
  logic [SQ_W-1:0] sbit, strial;
  logic [CNT_W-1:0] n_cur, limit;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0] rr;
  logic [DV_W-1:0] qfin;
  logic [DEN_W-1:0] rfin;
  logic signed [Q_W-1:0] qadj;
  logic [DEN_W-1:0] radj;
  logic [DEN_W:0] sumx, sumy;
  logic cx, cy;
  logic signed [Q_W-1:0] nqx, nqy;
  logic signed [COORD_W-1:0] nx, ny;
  logic is_end, more_close, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_INTERVAL) ? PDATA_W'(interval_q) : '0;

  assign ax = edge_close_q ? cur_x_q : prev_x_q;
  assign ay = edge_close_q ? cur_y_q : prev_y_q;
  assign bx = edge_close_q ? fig_x_q : cur_x_q;
  assign by = edge_close_q ? fig_y_q : cur_y_q;
  assign dx = D_W'(bx) - D_W'(ax);
  assign dy = D_W'(by) - D_W'(ay);
  assign dsel = (state_q == ST_MUL_Y) ? dy : dx;
  assign prod = SQ_W'(dsel) * SQ_W'(dsel);

  assign sbit   = SQ_W'(1) << (SQ_W - 2 - 2 * it_q);
  assign strial = r_q + sbit;

  assign is_end     = cur_type_q[TYPE_END_BIT];
  assign more_close = is_end && (m_q > CNT_W'(1));
  assign n_cur      = edge_close_q ? m_q : n_q;
  assign den        = {n_cur, 1'b0};
  assign limit      = edge_close_q ? m_q - CNT_W'(1) : n_q;

  // one restoring divide step on the magnitude of 2d
  assign rr   = {drem_q, dv_q[DV_W-1]};
  assign qfin = {dv_q[DV_W-2:0], (rr >= (DEN_W+1)'(den))};
  assign rfin = (rr >= (DEN_W+1)'(den)) ? DEN_W'(rr - (DEN_W+1)'(den)) : DEN_W'(rr);
  always_comb begin
    if (!dneg_q) begin
      qadj = Q_W'(qfin);
      radj = rfin;
    end else if (rfin == '0) begin
      qadj = -Q_W'(qfin);
      radj = '0;
    end else begin
      qadj = -(Q_W'(qfin) + Q_W'(1));
      radj = den - rfin;
    end
  end

  // stepping the rounded piece point
  assign sumx = (DEN_W+1)'(remx_q) + (DEN_W+1)'(rx_q);
  assign sumy = (DEN_W+1)'(remy_q) + (DEN_W+1)'(ry_q);
  assign cx   = sumx >= (DEN_W+1)'(den);
  assign cy   = sumy >= (DEN_W+1)'(den);
  assign nqx  = accx_q + qx_q + Q_W'(cx);
  assign nqy  = accy_q + qy_q + Q_W'(cy);
  assign nx   = COORD_W'(Q_W'(ax) + nqx);
  assign ny   = COORD_W'(Q_W'(ay) + nqy);

  always_comb begin
    logic signed [D_W-1:0] dd;
    logic [DV_W-1:0] twod;
    logic [CNT_W-1:0] cdone;
    logic [SQ_W-1:0] sqsum;
    state_d = state_q;
    prev_x_d = prev_x_q; prev_y_d = prev_y_q; prev_type_d = prev_type_q;
    cur_x_d = cur_x_q; cur_y_d = cur_y_q; cur_type_d = cur_type_q;
    fig_x_d = fig_x_q; fig_y_d = fig_y_q;
    have_prev_d = have_prev_q; skip_d = skip_q; opens_d = opens_q;
    edge_close_d = edge_close_q;
    s_d = s_q; r_d = r_q; it_d = it_q; root_d = root_q;
    cnt_d = cnt_q; n_d = n_q; m_d = m_q; k_d = k_q;
    dv_d = dv_q; drem_d = drem_q; dneg_d = dneg_q;
    qx_d = qx_q; qy_d = qy_q; rx_d = rx_q; ry_d = ry_q;
    accx_d = accx_q; accy_d = accy_q; remx_d = remx_q; remy_d = remy_q;
    px_d = px_q; py_d = py_q;
    seg_d = seg_q;
    seg_valid_d = seg_valid_q && !seg_o.ready;
    point_i.ready = (state_q == ST_IDLE);
    cdone = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
    dd = (state_q == ST_DIV_Y) ? dy : dx;
    twod = dd[D_W-1] ? DV_W'(-{dd, 1'b0}) : DV_W'({dd, 1'b0});
    sqsum = s_q + SQ_W'(prod);

    unique case (state_q)
      ST_IDLE: begin
        if (point_i.valid) begin
          if (!have_prev_q || skip_q) begin
            have_prev_d = 1'b1;
            skip_d = 1'b0;
            prev_x_d = point_i.data.point_x;
            prev_y_d = point_i.data.point_y;
            prev_type_d = point_i.data.point_type;
          end else begin
            cur_x_d = point_i.data.point_x;
            cur_y_d = point_i.data.point_y;
            cur_type_d = point_i.data.point_type;
            opens_d = (prev_type_q == '0);
            if (prev_type_q == '0) begin
              fig_x_d = prev_x_q;
              fig_y_d = prev_y_q;
            end
            edge_close_d = 1'b0;
            state_d = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        s_d = SQ_W'(prod);
        state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        s_d = sqsum;
        r_d = '0;
        it_d = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (s_q >= strial) begin
          s_d = s_q - strial;
          r_d = (r_q >> 1) + sbit;
        end else begin
          r_d = r_q >> 1;
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(SQRT_STEPS - 1)) begin
          state_d = ST_QUOT;
          cnt_d = '0;
        end
      end
      ST_QUOT: begin
        if (r_q != '0 && it_q == 5'(SQRT_STEPS)) begin
          root_d = RT_W'(r_q);
        end
        it_d = '0;
        if (it_q == 5'(SQRT_STEPS)) begin
          root_d = RT_W'(r_q);
        end else if (interval_q == '0) begin
          cnt_d = MAX_CNT;
        end else if (root_q >= RT_W'(interval_q) && cnt_q < MAX_CNT) begin
          root_d = root_q - RT_W'(interval_q);
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (it_q != 5'(SQRT_STEPS) &&
            (interval_q == '0 || root_q < RT_W'(interval_q) || cnt_q >= MAX_CNT)) begin
          if (interval_q == '0) cdone = MAX_CNT;
          if (!edge_close_q) begin
            n_d = cdone;
            if (is_end) begin
              edge_close_d = 1'b1;
              state_d = ST_MUL_X;
            end else begin
              state_d = ST_DIV_X;
            end
          end else begin
            m_d = cdone;
            edge_close_d = 1'b0;
            state_d = ST_DIV_X;
          end
          it_d = 5'd31;
        end
      end
      ST_DIV_X, ST_DIV_Y: begin
        // it_q of all ones marks the load cycle
        if (it_q == 5'd31) begin
          dv_d = twod;
          dneg_d = dd[D_W-1];
          drem_d = '0;
          it_d = '0;
        end else begin
          dv_d = qfin;
          drem_d = rfin;
          it_d = it_q + 5'd1;
          if (it_q == 5'(DIV_STEPS - 1)) begin
            if (state_q == ST_DIV_X) begin
              qx_d = qadj;
              rx_d = radj;
              it_d = 5'd31;
              state_d = ST_DIV_Y;
            end else begin
              qy_d = qadj;
              ry_d = radj;
              accx_d = '0;
              accy_d = '0;
              remx_d = DEN_W'(n_cur);
              remy_d = DEN_W'(n_cur);
              px_d = ax;
              py_d = ay;
              k_d = CNT_W'(1);
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!seg_valid_q || seg_o.ready) begin
          seg_valid_d = 1'b1;
          seg_d.seg_start_x = px_q;
          seg_d.seg_start_y = py_q;
          seg_d.seg_end_x = nx;
          seg_d.seg_end_y = ny;
          seg_d.opens_figure = !edge_close_q && (k_q == CNT_W'(1)) && opens_q;
          seg_d.sets_marker = !edge_close_q && (k_q == limit) &&
                              cur_type_q[TYPE_MARKER_BIT];
          seg_d.last_of_run = (k_q == limit) && (edge_close_q || !more_close);
          seg_d.closes_figure = seg_d.last_of_run && is_end;
          px_d = nx;
          py_d = ny;
          accx_d = nqx;
          accy_d = nqy;
          remx_d = cx ? DEN_W'(sumx - (DEN_W+1)'(den)) : DEN_W'(sumx);
          remy_d = cy ? DEN_W'(sumy - (DEN_W+1)'(den)) : DEN_W'(sumy);
          k_d = k_q + CNT_W'(1);
          if (k_q == limit) begin
            if (!edge_close_q && more_close) begin
              edge_close_d = 1'b1;
              it_d = 5'd31;
              state_d = ST_DIV_X;
            end else begin
              prev_x_d = cur_x_q;
              prev_y_d = cur_y_q;
              prev_type_d = cur_type_q;
              skip_d = is_end;
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign seg_o.valid = seg_valid_q;
  assign seg_o.data  = seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      interval_q <= INTERVAL_RESET;
      prev_x_q <= '0; prev_y_q <= '0; prev_type_q <= '0;
      fig_x_q <= '0; fig_y_q <= '0;
      have_prev_q <= 1'b0; skip_q <= 1'b0;
      seg_valid_q <= 1'b0;
      edge_close_q <= 1'b0;
      it_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr[2] == REG_INTERVAL) interval_q <= pwdata[CFG_W-1:0];
      prev_x_q <= prev_x_d; prev_y_q <= prev_y_d; prev_type_q <= prev_type_d;
      fig_x_q <= fig_x_d; fig_y_q <= fig_y_d;
      have_prev_q <= have_prev_d; skip_q <= skip_d;
      seg_valid_q <= seg_valid_d;
      edge_close_q <= edge_close_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d; cur_y_q <= cur_y_d; cur_type_q <= cur_type_d;
    opens_q <= opens_d;
    s_q <= s_d; r_q <= r_d; root_q <= root_d;
    cnt_q <= cnt_d; n_q <= n_d; m_q <= m_d; k_q <= k_d;
    dv_q <= dv_d; drem_q <= drem_d; dneg_q <= dneg_d;
    qx_q <= qx_d; qy_q <= qy_d; rx_q <= rx_d; ry_q <= ry_d;
    accx_q <= accx_d; accy_q <= accy_d; remx_q <= remx_d; remy_q <= remy_d;
    px_q <= px_d; py_q <= py_d;
    seg_q <= seg_d;
  end

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> k_q >= CNT_W'(1) && k_q <= limit)
    else $error("piece index out of range");

  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_q && seg_q.closes_figure |-> seg_q.last_of_run)
    else $error("close flag off the final beat");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_X || state_q == ST_DIV_Y) |-> n_cur != '0)
    else $error("zero piece count in divide");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && seg_valid_d && !seg_valid_q && seg_d.last_of_run
      |=> state_q == ST_IDLE)
    else $error("sequencer kept busy after final beat");

endmodule
